// File: hdl/caf_pkg.sv
`timescale 1ns / 1ps
package caf_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int ATAN_LEN = 24;
	localparam int CORDIC_W = 36;
	localparam int PROD_W = 58;

	localparam logic signed [15:0] BIAS_RST = 16'sd0;
	localparam logic [23:0] GAIN_RST = 24'd5000;
	localparam logic [16:0] WEIGHT_RST = 17'd64880;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;
	localparam logic signed [31:0] NINETY_DEG = 32'sd5898240;

	localparam logic [2:0] REG_BIAS_X = 3'd0;
	localparam logic [2:0] REG_BIAS_Y = 3'd1;
	localparam logic [2:0] REG_BIAS_Z = 3'd2;
	localparam logic [2:0] REG_GAIN = 3'd3;
	localparam logic [2:0] REG_WEIGHT = 3'd4;
	localparam logic [2:0] REG_ENABLE = 3'd5;

	typedef struct packed {
		logic en;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} item_t;

	typedef struct packed {
		logic start;
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
	} cordic_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] z;
	} cordic_rsp_t;

	function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0: r = 32'sd2949120;
			5'd1: r = 32'sd1740967;
			5'd2: r = 32'sd919879;
			5'd3: r = 32'sd466945;
			5'd4: r = 32'sd234379;
			5'd5: r = 32'sd117304;
			5'd6: r = 32'sd58666;
			5'd7: r = 32'sd29335;
			5'd8: r = 32'sd14668;
			5'd9: r = 32'sd7334;
			5'd10: r = 32'sd3667;
			5'd11: r = 32'sd1833;
			5'd12: r = 32'sd917;
			5'd13: r = 32'sd458;
			5'd14: r = 32'sd229;
			5'd15: r = 32'sd115;
			5'd16: r = 32'sd57;
			5'd17: r = 32'sd29;
			5'd18: r = 32'sd14;
			5'd19: r = 32'sd7;
			5'd20: r = 32'sd4;
			5'd21: r = 32'sd2;
			5'd22: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = 58'sh7FFFFFFF;
		lo = -58'sh80000000;
		if (v > hi)
			return 32'sh7FFFFFFF;
		else if (v < lo)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		if (v > 17'sd32767)
			return 16'sh7FFF;
		else if (v < -17'sd32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

endpackage

// File: hdl/caf_front.sv
`timescale 1ns / 1ps
module caf_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	input  logic signed [15:0] rate_z,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] bias_x,
	input  logic signed [15:0] bias_y,
	input  logic signed [15:0] bias_z,
	input  logic enable,
	output logic q_valid,
	output caf_pkg::item_t q_item,
	input  logic q_pop
);

	caf_pkg::item_t fifo_q [2];
	caf_pkg::item_t item;
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;

	// Bias removal and saturation happen here so the back end sees clean rates.
	always_comb begin
		item.en = enable;
		item.rate_x = caf_pkg::sat16($signed({rate_x[15], rate_x}) - $signed({bias_x[15], bias_x}));
		item.rate_y = caf_pkg::sat16($signed({rate_y[15], rate_y}) - $signed({bias_y[15], bias_y}));
		item.rate_z = caf_pkg::sat16($signed({rate_z[15], rate_z}) - $signed({bias_z[15], bias_z}));
		item.accel_x = accel_x;
		item.accel_y = accel_y;
		item.accel_z = accel_z;
	end

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (count_q != 2'd0);
	assign q_item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !q_pop)
				count_q <= count_q + 2'd1;
			else if (!push && q_pop)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

// File: hdl/caf_cordic.sv
`timescale 1ns / 1ps
module caf_cordic #(
	parameter int ITERATIONS = caf_pkg::CORDIC_ITERATIONS
) (
	input  logic clk,
	input  logic arst_n,
	input  caf_pkg::cordic_req_t req,
	output caf_pkg::cordic_rsp_t rsp
);

	localparam int NI = (ITERATIONS < caf_pkg::ATAN_LEN) ? ITERATIONS : caf_pkg::ATAN_LEN;
	localparam int CNT_W = $clog2(NI);
	localparam int W = caf_pkg::CORDIC_W;

	logic signed [W-1:0] x_q;
	logic signed [W-1:0] y_q;
	logic signed [31:0] z_q;
	logic zero_q;
	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [W-1:0] xs;
	logic signed [W-1:0] ys;
	logic signed [31:0] ang;

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign ang = caf_pkg::atan_q16(5'(cnt_q));

	always_ff @(posedge clk) begin
		if (req.start) begin
			zero_q <= (req.x == '0) && (req.y == '0);
			// Left half plane: rotate by a quarter turn first.
			if (req.x[W-1]) begin
				if (!req.y[W-1]) begin
					x_q <= req.y;
					y_q <= -req.x;
					z_q <= caf_pkg::NINETY_DEG;
				end else begin
					x_q <= -req.y;
					y_q <= req.x;
					z_q <= -caf_pkg::NINETY_DEG;
				end
			end else begin
				x_q <= req.x;
				y_q <= req.y;
				z_q <= 32'sd0;
			end
		end else if (busy_q) begin
			if (!y_q[W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NI - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done = done_q;
	assign rsp.z = zero_q ? 32'sd0 : z_q;

endmodule

// File: hdl/caf_back.sv
`timescale 1ns / 1ps
module caf_back #(
	parameter int CORDIC_ITERATIONS = caf_pkg::CORDIC_ITERATIONS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  caf_pkg::item_t q_item,
	output logic q_pop,
	input  logic [23:0] rate_step_gain,
	input  logic [16:0] blend_weight,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] pitch_out,
	output logic signed [31:0] roll_out,
	output logic signed [31:0] yaw_out
);

	localparam int PW = caf_pkg::PROD_W;

	typedef enum logic [16:0] {
		S_IDLE = 17'h00001,
		S_SQA  = 17'h00002,
		S_SQB  = 17'h00004,
		S_GX   = 17'h00008,
		S_GY   = 17'h00010,
		S_GZ   = 17'h00020,
		S_ROOT = 17'h00040,
		S_CPG  = 17'h00080,
		S_CPW  = 17'h00100,
		S_CRG  = 17'h00200,
		S_CRW  = 17'h00400,
		S_BP1  = 17'h00800,
		S_BP2  = 17'h01000,
		S_BR1  = 17'h02000,
		S_BR2  = 17'h04000,
		S_FIN  = 17'h08000,
		S_OUT  = 17'h10000
	} state_t;

	state_t state_q;
	caf_pkg::item_t it_q;
	caf_pkg::cordic_req_t creq;
	caf_pkg::cordic_rsp_t crsp;

	logic signed [31:0] pitch_q;
	logic signed [31:0] roll_q;
	logic signed [31:0] yaw_q;
	logic signed [31:0] p_int_q;
	logic signed [31:0] r_int_q;
	logic signed [31:0] acc_p_q;
	logic signed [31:0] acc_r_q;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] acc_q;
	logic [31:0] sq_q;
	logic [63:0] sqsh_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0] cnt_q;
	logic out_valid_q;

	logic signed [32:0] mul_a;
	logic signed [24:0] mul_b;
	logic [16:0] w_gyro;
	logic [16:0] w_acc;
	logic signed [PW-1:0] step_d;
	logic signed [PW-1:0] blend_s;
	logic [35:0] rem_n;
	logic [35:0] trial;
	logic out_load;

	caf_cordic #(
		.ITERATIONS(CORDIC_ITERATIONS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.req(creq),
		.rsp(crsp)
	);

	assign w_gyro = (blend_weight > caf_pkg::WEIGHT_ONE) ? caf_pkg::WEIGHT_ONE : blend_weight;
	assign w_acc = caf_pkg::WEIGHT_ONE - w_gyro;

	// Gyro step is the previous product, rounded to nearest and shifted right by eight bits.
	assign step_d = (prod_q + 58'sd128) >>> 8;
	assign blend_s = (acc_q + prod_q + 58'sd32768) >>> 16;

	assign rem_n = {rem_q, sqsh_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// One shared multiplier; its product is registered and read in the next state.
	always_comb begin
		mul_a = 33'sd0;
		mul_b = 25'sd0;
		unique case (state_q)
			S_SQA: begin
				mul_a = $signed({{17{it_q.accel_y[15]}}, it_q.accel_y});
				mul_b = $signed({{9{it_q.accel_y[15]}}, it_q.accel_y});
			end
			S_SQB: begin
				mul_a = $signed({{17{it_q.accel_z[15]}}, it_q.accel_z});
				mul_b = $signed({{9{it_q.accel_z[15]}}, it_q.accel_z});
			end
			S_GX: begin
				mul_a = $signed({{17{it_q.rate_x[15]}}, it_q.rate_x});
				mul_b = $signed({1'b0, rate_step_gain});
			end
			S_GY: begin
				mul_a = $signed({{17{it_q.rate_y[15]}}, it_q.rate_y});
				mul_b = $signed({1'b0, rate_step_gain});
			end
			S_GZ: begin
				mul_a = $signed({{17{it_q.rate_z[15]}}, it_q.rate_z});
				mul_b = $signed({1'b0, rate_step_gain});
			end
			S_BP1: begin
				mul_a = $signed({p_int_q[31], p_int_q});
				mul_b = $signed({8'b0, w_gyro});
			end
			S_BP2: begin
				mul_a = $signed({acc_p_q[31], acc_p_q});
				mul_b = $signed({8'b0, w_acc});
			end
			S_BR1: begin
				mul_a = $signed({r_int_q[31], r_int_q});
				mul_b = $signed({8'b0, w_gyro});
			end
			S_BR2: begin
				mul_a = $signed({acc_r_q[31], acc_r_q});
				mul_b = $signed({8'b0, w_acc});
			end
			S_IDLE, S_ROOT, S_CPG, S_CPW, S_CRG, S_CRW, S_FIN, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		creq.start = (state_q == S_CPG) || (state_q == S_CRG);
		if (state_q == S_CPG) begin
			creq.x = $signed({4'b0, root_q});
			creq.y = $signed({{4{it_q.accel_x[15]}}, it_q.accel_x, 16'b0});
		end else begin
			creq.x = $signed({{4{it_q.accel_z[15]}}, it_q.accel_z, 16'b0});
			creq.y = $signed({{4{it_q.accel_y[15]}}, it_q.accel_y, 16'b0});
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (q_pop)
			it_q <= q_item;
		unique case (state_q)
			S_SQB: sq_q <= prod_q[31:0];
			S_GX: sq_q <= sq_q + prod_q[31:0];
			S_GY: p_int_q <= caf_pkg::sat32($signed({{26{pitch_q[31]}}, pitch_q}) + step_d);
			S_GZ: begin
				r_int_q <= caf_pkg::sat32($signed({{26{roll_q[31]}}, roll_q}) + step_d);
				sqsh_q <= {sq_q, 32'b0};
				rem_q <= '0;
				root_q <= '0;
			end
			S_ROOT: begin
				sqsh_q <= {sqsh_q[61:0], 2'b00};
				if (rem_n >= trial) begin
					rem_q <= 34'(rem_n - trial);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_n[33:0];
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			S_CPW: if (crsp.done) acc_p_q <= crsp.z;
			S_CRW: if (crsp.done) acc_r_q <= crsp.z;
			S_BP2: acc_q <= prod_q;
			S_BR2: acc_q <= prod_q;
			S_OUT: if (out_load) begin
				pitch_out <= pitch_q;
				roll_out <= roll_q;
				yaw_out <= yaw_q;
			end
			S_IDLE, S_SQA, S_CPG, S_CRG, S_BP1, S_BR1, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer, angle state and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			pitch_q <= '0;
			roll_q <= '0;
			yaw_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_valid) state_q <= q_item.en ? S_SQA : S_OUT;
				S_SQA: state_q <= S_SQB;
				S_SQB: state_q <= S_GX;
				S_GX: state_q <= S_GY;
				S_GY: state_q <= S_GZ;
				S_GZ: begin
					cnt_q <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (cnt_q == 5'd0)
						yaw_q <= caf_pkg::sat32($signed({{26{yaw_q[31]}}, yaw_q}) + step_d);
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31)
						state_q <= S_CPG;
				end
				S_CPG: state_q <= S_CPW;
				S_CPW: if (crsp.done) state_q <= S_CRG;
				S_CRG: state_q <= S_CRW;
				S_CRW: if (crsp.done) state_q <= S_BP1;
				S_BP1: state_q <= S_BP2;
				S_BP2: state_q <= S_BR1;
				S_BR1: begin
					pitch_q <= caf_pkg::sat32(blend_s);
					state_q <= S_BR2;
				end
				S_BR2: state_q <= S_FIN;
				S_FIN: begin
					roll_q <= caf_pkg::sat32(blend_s);
					state_q <= S_OUT;
				end
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: hdl/complementary_attitude_filter_top.sv
`timescale 1ns / 1ps
// The back end takes one beat at a time; it pops the next only when idle, after the square
// root and the two CORDIC passes through one shared unit (disabled beats skip both).
// A two-entry queue and an output register let input and output stall independently.
// Reset (asynchronous, active low) clears the angles to zero and loads register defaults.
module complementary_attitude_filter_top #(
	parameter int CORDIC_ITERATIONS = caf_pkg::CORDIC_ITERATIONS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	input  logic signed [15:0] rate_z,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] pitch_out,
	output logic signed [31:0] roll_out,
	output logic signed [31:0] yaw_out,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [23:0] cfg_data
);

	logic signed [15:0] bias_x_q;
	logic signed [15:0] bias_y_q;
	logic signed [15:0] bias_z_q;
	logic [23:0] gain_q;
	logic [16:0] weight_q;
	logic enable_q;
	logic q_valid;
	logic q_pop;
	caf_pkg::item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_x_q <= caf_pkg::BIAS_RST;
			bias_y_q <= caf_pkg::BIAS_RST;
			bias_z_q <= caf_pkg::BIAS_RST;
			gain_q <= caf_pkg::GAIN_RST;
			weight_q <= caf_pkg::WEIGHT_RST;
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				caf_pkg::REG_BIAS_X: bias_x_q <= cfg_data[15:0];
				caf_pkg::REG_BIAS_Y: bias_y_q <= cfg_data[15:0];
				caf_pkg::REG_BIAS_Z: bias_z_q <= cfg_data[15:0];
				caf_pkg::REG_GAIN: gain_q <= cfg_data;
				caf_pkg::REG_WEIGHT: weight_q <= cfg_data[16:0];
				caf_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	caf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rate_x(rate_x),
		.rate_y(rate_y),
		.rate_z(rate_z),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.bias_x(bias_x_q),
		.bias_y(bias_y_q),
		.bias_z(bias_z_q),
		.enable(enable_q),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	caf_back #(
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.rate_step_gain(gain_q),
		.blend_weight(weight_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pitch_out(pitch_out),
		.roll_out(roll_out),
		.yaw_out(yaw_out)
	);

endmodule
